### rtl/fat_cluster_chain_walker_assert.svh
// Assertion macros used by the chain walker top level
`ifndef FAT_CLUSTER_CHAIN_WALKER_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_WALKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcw: same-cycle check failed");

// next-cycle implication
`define FCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcw: next-cycle check failed");

`endif

### rtl/fcw_pkg.sv
// Package: constants, codes and control/status types of the chain walker
`timescale 1ns / 1ps
package fcw_pkg;

  localparam int FAT_BYTES_DEF    = 8192;
  localparam int MAX_CLUSTERS_DEF = 4096;

  // payload widths
  localparam int BYTE_ADDR_W = 13;
  localparam int CLUSTER_W   = 16;
  localparam int OUT_LEN_W   = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int CCOUNT_W    = 13;
  localparam int FLEN_W      = 14;

  // visited map tag width; a clearing pass runs when the tag wraps
  localparam int EPOCH_W = 4;

  // command codes of the input item
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_WALK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAT16_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_LEN    = 2'd2;

  localparam logic [FLEN_W-1:0] FAT_LEN_RST = 14'd512;

  // end-of-chain marks
  localparam logic [CLUSTER_W-1:0] END_MARK12 = 16'h0FF8;
  localparam logic [CLUSTER_W-1:0] END_MARK16 = 16'hFFF8;
  localparam logic [CLUSTER_W-1:0] MIN_LINK   = 16'd2;

  typedef struct packed {
    logic load;        // item transfer on the input channel
    logic write_byte;  // store the item's byte
    logic epoch_inc;   // new walk, next tag
    logic epoch_one;   // new walk after a clearing pass
    logic sweep;       // clear one visited entry
    logic rd_hi;       // read the second byte of the entry
    logic mark;        // append current cluster, tag it visited
    logic advance;     // follow the link
    logic load_out;    // move results into the output register
  } fcw_cmd_t;

  typedef struct packed {
    logic in_range;
    logic visited;
    logic beyond;
    logic is_end;
    logic sweep_last;
    logic epoch_max;
  } fcw_sts_t;

endpackage

### rtl/fcw_ifs.sv
// Channel interfaces: input items, result items, configuration writes
`timescale 1ns / 1ps
interface fcw_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [fcw_pkg::BYTE_ADDR_W-1:0] byte_addr;
  logic [7:0]                      byte_value;
  logic [fcw_pkg::CLUSTER_W-1:0]   start_cluster;
  logic [fcw_pkg::CLUSTER_W-1:0]   target_cluster;

  modport source (output valid, cmd, byte_addr, byte_value, start_cluster, target_cluster,
                  input ready);
  modport sink (input valid, cmd, byte_addr, byte_value, start_cluster, target_cluster,
                output ready);
endinterface

interface fcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [fcw_pkg::OUT_LEN_W-1:0] chain_length;
  logic                          target_found;
  logic [fcw_pkg::OUT_LEN_W-1:0] target_position;

  modport source (output valid, chain_length, target_found, target_position, input ready);
  modport sink (input valid, chain_length, target_found, target_position, output ready);
endinterface

interface fcw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fcw_pkg::CFG_IDX_W-1:0]  index;
  logic [fcw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/fcw_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/fcw_dp.sv
// Datapath: FAT byte store, visited tags, walk registers, config and result registers
`timescale 1ns / 1ps
module fcw_dp #(
  parameter int FAT_BYTES    = fcw_pkg::FAT_BYTES_DEF,
  parameter int MAX_CLUSTERS = fcw_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fcw_pkg::fcw_cmd_t                cmd,
  output fcw_pkg::fcw_sts_t                sts,
  // item payload
  input  logic [fcw_pkg::BYTE_ADDR_W-1:0]  in_byte_addr,
  input  logic [7:0]                       in_byte_value,
  input  logic [fcw_pkg::CLUSTER_W-1:0]    in_start_cluster,
  input  logic [fcw_pkg::CLUSTER_W-1:0]    in_target_cluster,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [fcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcw_pkg::CFG_DATA_W-1:0]   cfg_data,
  // result payload
  output logic [fcw_pkg::OUT_LEN_W-1:0]    out_chain_length,
  output logic                             out_target_found,
  output logic [fcw_pkg::OUT_LEN_W-1:0]    out_target_position
);

  localparam int AW        = $clog2(FAT_BYTES);
  localparam int MAP_DEPTH = MAX_CLUSTERS + 2;
  localparam int VW        = $clog2(MAP_DEPTH);
  localparam int CL_W      = $clog2(MAX_CLUSTERS + 3);  // holds the link limit
  localparam int PW        = CL_W + 1;                  // byte offset of an entry
  localparam int EW        = $clog2(FAT_BYTES + 1);
  localparam int CW0       = (PW + 1 > EW) ? PW + 1 : EW;
  localparam int CW1       = (CW0 > fcw_pkg::FLEN_W) ? CW0 : fcw_pkg::FLEN_W;
  localparam int CW        = (CW1 > fcw_pkg::BYTE_ADDR_W + 1) ? CW1 : fcw_pkg::BYTE_ADDR_W + 1;
  localparam int KW        = (CL_W > fcw_pkg::CLUSTER_W) ? CL_W : fcw_pkg::CLUSTER_W;
  localparam int CCW       = (CL_W > fcw_pkg::CCOUNT_W) ? CL_W : fcw_pkg::CCOUNT_W;
  localparam int EPW       = fcw_pkg::EPOCH_W;

  // configuration registers
  logic                         fat16_r;
  logic [fcw_pkg::CCOUNT_W-1:0] ccount_r;
  logic [fcw_pkg::FLEN_W-1:0]   flen_r;

  // walk registers
  logic [fcw_pkg::CLUSTER_W-1:0] cur_r;
  logic [fcw_pkg::CLUSTER_W-1:0] tgt_r;
  logic [CL_W-1:0]               len_r;
  logic [CL_W-1:0]               tpos_r;
  logic                          found_r;
  logic [7:0]                    b0_r;
  logic [EPW-1:0]                epoch_r;
  logic [VW-1:0]                 clr_r;

  // result registers
  logic [fcw_pkg::OUT_LEN_W-1:0] olen_r;
  logic                          ofound_r;
  logic [fcw_pkg::OUT_LEN_W-1:0] opos_r;

  logic [CCW-1:0]                ccount_x;
  logic [CL_W-1:0]               eff_cl;
  logic [CL_W-1:0]               limit;
  logic [CW-1:0]                 eff_len;
  logic [KW-1:0]                 cur_k;
  logic [CL_W-1:0]               cur_c;
  logic [PW-1:0]                 fpos;
  logic [PW-1:0]                 fpos_hi;
  logic                          addr_ok;
  logic [7:0]                    fat_rdata;
  logic [AW-1:0]                 fat_raddr;
  logic [15:0]                   word;
  logic [fcw_pkg::CLUSTER_W-1:0] entry;
  logic [EPW-1:0]                vis_rdata;
  logic                          vis_we;
  logic [VW-1:0]                 vis_waddr;
  logic [EPW-1:0]                vis_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat16_r  <= 1'b0;
      ccount_r <= '0;
      flen_r   <= fcw_pkg::FAT_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcw_pkg::REG_FAT16_MODE: fat16_r  <= cfg_data[0];
        fcw_pkg::REG_CLUSTERS:   ccount_r <= cfg_data[fcw_pkg::CCOUNT_W-1:0];
        fcw_pkg::REG_FAT_LEN:    flen_r   <= cfg_data[fcw_pkg::FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective cluster count, link limit and FAT length
  always_comb begin
    ccount_x = CCW'(ccount_r);
    eff_cl   = (ccount_x < CCW'(MAX_CLUSTERS)) ? CL_W'(ccount_x) : CL_W'(MAX_CLUSTERS);
    limit    = eff_cl + CL_W'(2);
    eff_len  = (CW'(flen_r) < CW'(FAT_BYTES)) ? CW'(flen_r) : CW'(FAT_BYTES);
  end

  // entry address: 2n for 16-bit entries, n + n/2 for 12-bit entries
  always_comb begin
    cur_k   = KW'(cur_r);
    cur_c   = CL_W'(cur_r);
    fpos    = fat16_r ? (PW'(cur_c) << 1) : (PW'(cur_c) + PW'(cur_c >> 1));
    fpos_hi = fpos + PW'(1);
    fat_raddr = cmd.rd_hi ? AW'(fpos_hi) : AW'(fpos);
    addr_ok   = CW'(in_byte_addr) < CW'(FAT_BYTES);
  end

  // entry decode: b0_r holds the low byte, the RAM output the high byte
  always_comb begin
    word = {fat_rdata, b0_r};
    if (fat16_r) begin
      entry = word;
    end else if (cur_r[0]) begin
      entry = {4'h0, word[15:4]};
    end else begin
      entry = {4'h0, word[11:0]};
    end
  end

  always_comb begin
    sts.in_range   = (cur_k >= KW'(fcw_pkg::MIN_LINK)) && (cur_k < KW'(limit)) &&
                     (len_r < limit);
    sts.visited    = (vis_rdata == epoch_r);
    sts.beyond     = CW'(fpos_hi) >= eff_len;
    sts.is_end     = (entry < fcw_pkg::MIN_LINK) ||
                     (fat16_r ? (entry >= fcw_pkg::END_MARK16)
                              : (entry >= fcw_pkg::END_MARK12));
    sts.sweep_last = (clr_r == VW'(MAP_DEPTH - 1));
    sts.epoch_max  = &epoch_r;
  end

  always_comb begin
    vis_we    = cmd.sweep | cmd.mark;
    vis_waddr = cmd.sweep ? clr_r : VW'(cur_c);
    vis_wdata = cmd.sweep ? '0 : epoch_r;
  end

  fcw_ram #(
    .WIDTH (8),
    .DEPTH (FAT_BYTES)
  ) u_fat_ram (
    .clk   (clk),
    .we    (cmd.write_byte & addr_ok),
    .waddr (AW'(in_byte_addr)),
    .wdata (in_byte_value),
    .raddr (fat_raddr),
    .rdata (fat_rdata)
  );

  fcw_ram #(
    .WIDTH (EPW),
    .DEPTH (MAP_DEPTH)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (VW'(cur_c)),
    .rdata (vis_rdata)
  );

  // tag and clearing-pass pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= '0;
      clr_r   <= '0;
    end else begin
      if (cmd.epoch_one) begin
        epoch_r <= EPW'(1);
      end else if (cmd.epoch_inc) begin
        epoch_r <= epoch_r + EPW'(1);
      end
      if (cmd.sweep) begin
        clr_r <= sts.sweep_last ? '0 : clr_r + VW'(1);
      end
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r   <= in_start_cluster;
      tgt_r   <= in_target_cluster;
      len_r   <= '0;
      tpos_r  <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.mark) begin
        len_r <= len_r + CL_W'(1);
        b0_r  <= fat_rdata;
        if (!found_r && (cur_r == tgt_r)) begin
          found_r <= 1'b1;
          tpos_r  <= len_r;
        end
      end
      if (cmd.advance) begin
        cur_r <= entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      olen_r   <= fcw_pkg::OUT_LEN_W'(len_r);
      ofound_r <= found_r;
      opos_r   <= fcw_pkg::OUT_LEN_W'(tpos_r);
    end
  end

  assign out_chain_length    = olen_r;
  assign out_target_found    = ofound_r;
  assign out_target_position = opos_r;

endmodule

### rtl/fcw_ctrl.sv
// Controller: sequences clearing passes, byte writes, link steps and result handoff
`timescale 1ns / 1ps
module fcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic              out_ready,
  input  fcw_pkg::fcw_sts_t sts,
  output fcw_pkg::fcw_cmd_t cmd,
  output logic              in_ready,
  output logic              out_valid
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WRAP,
    S_CHECK,
    S_VIS,
    S_NXT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept = in_ready_r & in_valid;

  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.write_byte = accept && (in_cmd == fcw_pkg::CMD_WRITE);
    cmd.epoch_inc  = accept && (in_cmd == fcw_pkg::CMD_WALK) && !sts.epoch_max;
    cmd.sweep      = (state_r == S_INIT) || (state_r == S_WRAP);
    cmd.epoch_one  = (state_r == S_WRAP) && sts.sweep_last;
    cmd.rd_hi      = (state_r == S_VIS);
    cmd.mark       = (state_r == S_VIS) && !sts.visited;
    cmd.advance    = (state_r == S_NXT) && !sts.is_end;
    cmd.load_out   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == fcw_pkg::CMD_WRITE) begin
            state_nxt = S_DONE;
          end else if (sts.epoch_max) begin
            state_nxt = S_WRAP;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_WRAP: begin
        if (sts.sweep_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.in_range ? S_VIS : S_DONE;
      end
      S_VIS: begin
        // an entry past the FAT length ends the chain
        if (sts.visited || sts.beyond) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NXT;
        end
      end
      S_NXT: begin
        state_nxt = sts.is_end ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

### rtl/fat_cluster_chain_walker.sv
// FAT12/FAT16 chain walker: top level joining controller and datapath
// Holds one FAT copy in a byte RAM filled by write items (cmd 0) and follows a
// cluster chain for walk items (cmd 1), returning its length and the position
// of the target cluster. A write item goes through the done state to the output
// register. Each link passes a check state (check the cluster, issue the
// visited-tag and low-byte reads), a visit state (test the tag, read the high
// byte) and a next state (decode the entry), set by the single FAT read port.
// Visited clusters are tagged with a 4-bit walk number, so the map needs no
// clearing between walks; once after reset and before each walk that finds the
// tag at its top value, all MAX_CLUSTERS+2 tag entries are swept, with no item
// taken meanwhile. Config writes are always taken; change them only when idle.
// The next item is taken while a result still waits in the output register.
`timescale 1ns / 1ps
module fat_cluster_chain_walker #(
  parameter int FAT_BYTES    = fcw_pkg::FAT_BYTES_DEF,
  parameter int MAX_CLUSTERS = fcw_pkg::MAX_CLUSTERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fcw_in_if.sink    in_ch,
  fcw_out_if.source out_ch,
  fcw_cfg_if.sink   cfg_ch
);

  fcw_pkg::fcw_cmd_t dp_cmd;
  fcw_pkg::fcw_sts_t dp_sts;

  assign cfg_ch.ready = 1'b1;

  fcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .out_ready (out_ch.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  fcw_dp #(
    .FAT_BYTES    (FAT_BYTES),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (dp_cmd),
    .sts                 (dp_sts),
    .in_byte_addr        (in_ch.byte_addr),
    .in_byte_value       (in_ch.byte_value),
    .in_start_cluster    (in_ch.start_cluster),
    .in_target_cluster   (in_ch.target_cluster),
    .cfg_we              (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .out_chain_length    (out_ch.chain_length),
    .out_target_found    (out_ch.target_found),
    .out_target_position (out_ch.target_position)
  );

`include "fat_cluster_chain_walker_assert.svh"

  // only an in-range cluster is ever appended to the chain
  `FCW_ASSERT_IMP(a_mark_in_range, dp_cmd.mark, dp_sts.in_range)
  // a link is followed only after both entry bytes were inside the FAT
  `FCW_ASSERT_IMP(a_adv_in_fat, dp_cmd.advance, !dp_sts.beyond)
  // no item transfer while the tag RAM is being swept
  `FCW_ASSERT_IMP(a_sweep_blocks, dp_cmd.sweep, !in_ch.ready)
  // a result loaded into the output register is offered next cycle
  `FCW_ASSERT_NXT(a_load_shows, dp_cmd.load_out, out_ch.valid)

endmodule
